[sv/ktw_pkg.sv]
// Shared types, constants and knight move tables for the knight's tour step unit.
// No dependencies; imported by ktw_if, the step unit and ktw_ctrl.
package ktw_pkg;

  localparam int MaxSideDef = 16;   // default largest board side
  localparam int CoordW     = 4;    // row / column width on the ports
  localparam int StepW      = 8;    // move number width
  localparam int SideW      = 5;    // board_side register width
  localparam int PosW       = 7;    // signed width of a probed coordinate
  localparam int CntW       = 4;    // onward count, 0..9
  localparam int DirW       = 3;    // eight knight directions
  localparam int LookW      = 4;    // lookup index, 0..8

  localparam logic [SideW-1:0] SideReset = SideW'(8);
  localparam logic [CntW-1:0]  NoCount   = CntW'(9);
  localparam logic [LookW-1:0] LastLook  = LookW'(8);
  localparam logic [DirW-1:0]  LastDir   = DirW'(7);

  // action codes
  localparam logic ActStart = 1'b0;
  localparam logic ActStep  = 1'b1;

  typedef logic signed [PosW-1:0] pos_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_SCAN,
    ST_TAIL,
    ST_RMW_RD,
    ST_RMW_WR,
    ST_DONE
  } ktw_state_t;

  typedef struct packed {
    logic              moved;
    logic [CoordW-1:0] cur_row;
    logic [CoordW-1:0] cur_col;
    logic [StepW-1:0]  move_number;
  } ktw_res_t;

  // row offset of knight direction d
  function automatic pos_t knight_dr(input logic [DirW-1:0] d);
    pos_t v;
    case (d)
      3'd0: v = pos_t'(2);
      3'd1: v = pos_t'(1);
      3'd2: v = pos_t'(-2);
      3'd3: v = pos_t'(-1);
      3'd4: v = pos_t'(-2);
      3'd5: v = pos_t'(-1);
      3'd6: v = pos_t'(2);
      3'd7: v = pos_t'(1);
      default: v = pos_t'(0);
    endcase
    return v;
  endfunction

  // column offset of knight direction d
  function automatic pos_t knight_dc(input logic [DirW-1:0] d);
    pos_t v;
    case (d)
      3'd0: v = pos_t'(1);
      3'd1: v = pos_t'(2);
      3'd2: v = pos_t'(1);
      3'd3: v = pos_t'(2);
      3'd4: v = pos_t'(-1);
      3'd5: v = pos_t'(-2);
      3'd6: v = pos_t'(-1);
      3'd7: v = pos_t'(-2);
      default: v = pos_t'(0);
    endcase
    return v;
  endfunction

endpackage

[sv/ktw_if.sv]
// Valid/ready channel interfaces: input word, result word and board_side write.
// Depends on ktw_pkg for field widths.
interface ktw_in_if import ktw_pkg::*;;
  logic              valid;
  logic              ready;
  logic              action;
  logic [CoordW-1:0] start_row;
  logic [CoordW-1:0] start_col;
  logic [DirW-1:0]   rotation_pick;

  modport source (output valid, action, start_row, start_col, rotation_pick, input ready);
  modport sink   (input valid, action, start_row, start_col, rotation_pick, output ready);
endinterface

interface ktw_out_if import ktw_pkg::*;;
  logic              valid;
  logic              ready;
  logic              moved;
  logic [CoordW-1:0] cur_row;
  logic [CoordW-1:0] cur_col;
  logic [StepW-1:0]  move_number;

  modport source (output valid, moved, cur_row, cur_col, move_number, input ready);
  modport sink   (input valid, moved, cur_row, cur_col, move_number, output ready);
endinterface

interface ktw_cfg_if import ktw_pkg::*;;
  logic             valid;
  logic             ready;
  logic [SideW-1:0] board_side;

  modport source (output valid, board_side, input ready);
  modport sink   (input valid, board_side, output ready);
endinterface

[sv/knight_tour_warnsdorff_step_unit.sv]
// Knight's tour step unit (Warnsdorff rule): board_side register, map RAM,
// sequencer and result register. Depends on ktw_pkg, ktw_if, ktw_map_ram, ktw_ctrl.
// Step word: 72 pipelined map reads, then a read-modify-write of the chosen square if one is found.
// Valid start word: row-per-cycle clearing sweep of the map; a rejected start only returns a result.
// One word at a time: in_ch.ready is high only in idle; result register frees the sequencer.
// Reset: clearing pass of all MAX_SIDE map rows with in_ch.ready low; board_side = 8.
module knight_tour_warnsdorff_step_unit import ktw_pkg::*; #(
  parameter int MAX_SIDE = MaxSideDef
) (
  input  logic        clk,
  input  logic        rst_n,
  ktw_in_if.sink      in_ch,
  ktw_out_if.source   out_ch,
  ktw_cfg_if.sink     cfg_ch
);

  localparam int RowIdxW = $clog2(MAX_SIDE);

  logic [SideW-1:0]   board_side_r;
  logic [SideW-1:0]   side_use;
  logic               res_valid, res_ready;
  ktw_res_t           res;
  logic               out_valid_r;
  ktw_res_t           out_res_r;
  logic               map_we;
  logic [RowIdxW-1:0] map_waddr, map_raddr;
  logic [MAX_SIDE-1:0] map_wdata, map_rdata;

  // configuration register
  assign cfg_ch.ready = 1'b1;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      board_side_r <= SideReset;
    end else if (cfg_ch.valid) begin
      board_side_r <= cfg_ch.board_side;
    end
  end

  // side in use: zero reads as one, large values clip to MAX_SIDE
  always_comb begin
    side_use = board_side_r;
    if (board_side_r == '0) side_use = SideW'(1);
    else if (board_side_r > SideW'(MAX_SIDE)) side_use = SideW'(MAX_SIDE);
  end

  ktw_map_ram #(.Depth(MAX_SIDE), .Width(MAX_SIDE)) u_map (
    .clk   (clk),
    .we    (map_we),
    .waddr (map_waddr),
    .wdata (map_wdata),
    .raddr (map_raddr),
    .rdata (map_rdata)
  );

  ktw_ctrl #(.MAX_SIDE(MAX_SIDE)) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .side_use  (side_use),
    .in_ch     (in_ch),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res       (res),
    .map_we    (map_we),
    .map_waddr (map_waddr),
    .map_wdata (map_wdata),
    .map_raddr (map_raddr),
    .map_rdata (map_rdata)
  );

  // result register
  assign res_ready = ~out_valid_r | out_ch.ready;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (res_ready) begin
      out_valid_r <= res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (res_ready && res_valid) out_res_r <= res;
  end

  assign out_ch.valid       = out_valid_r;
  assign out_ch.moved       = out_res_r.moved;
  assign out_ch.cur_row     = out_res_r.cur_row;
  assign out_ch.cur_col     = out_res_r.cur_col;
  assign out_ch.move_number = out_res_r.move_number;

endmodule

[sv/ktw_map_ram.sv]
// Visited map: one row of the board per entry, one write and one read port,
// registered read data. Depends on nothing else.
module ktw_map_ram #(
  parameter int Depth = 16,
  parameter int Width = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(Depth)-1:0] waddr,
  input  logic [Width-1:0]         wdata,
  input  logic [$clog2(Depth)-1:0] raddr,
  output logic [Width-1:0]         rdata
);

  logic [Width-1:0] mem [Depth];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // read port, registered
  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

[sv/ktw_ctrl.sv]
// Tour sequencer: clearing sweep, pipelined Warnsdorff scan over the map RAM,
// read-modify-write of the chosen square. Depends on ktw_pkg and ktw_if.
module ktw_ctrl import ktw_pkg::*; #(
  parameter int MAX_SIDE = MaxSideDef
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic [SideW-1:0]            side_use,
  ktw_in_if.sink                      in_ch,
  output logic                        res_valid,
  input  logic                        res_ready,
  output ktw_res_t                    res,
  output logic                        map_we,
  output logic [$clog2(MAX_SIDE)-1:0] map_waddr,
  output logic [MAX_SIDE-1:0]         map_wdata,
  output logic [$clog2(MAX_SIDE)-1:0] map_raddr,
  input  logic [MAX_SIDE-1:0]         map_rdata
);

  localparam int RowIdxW = $clog2(MAX_SIDE);
  localparam logic [RowIdxW-1:0] LastRow = RowIdxW'(MAX_SIDE - 1);

  ktw_state_t state_r, state_nxt;

  // item and walk state
  logic              start_ok;
  logic              set_en_r;
  logic [CoordW-1:0] srow_r, scol_r;
  logic [DirW-1:0]   pick_r;
  logic [CoordW-1:0] here_row_r, here_col_r;
  logic [StepW-1:0]  count_r;
  logic              moved_r;
  logic [RowIdxW-1:0] sw_r;

  // scan counters and best candidate
  logic [DirW-1:0]   i_r;
  logic [LookW-1:0]  j_r;
  logic [CntW-1:0]   best_r;
  logic [DirW-1:0]   bdir_r;
  logic              cand_free_r;
  logic [CntW-1:0]   cnt_r;

  // read pipeline stage
  logic               pb_vld_r, pb_j0_r, pb_jlast_r, pb_onb_r;
  logic [RowIdxW-1:0] pb_col_r;
  logic [DirW-1:0]    pb_dir_r;

  // probe address of the current lookup
  logic [DirW-1:0] dir_a, nb_a;
  pos_t            here_r_pos, here_c_pos, side_pos, r_a, c_a;
  logic            onb_a;
  logic            scan_last;
  logic            found;
  pos_t            tgt_r, tgt_c;
  logic [CoordW-1:0] tgt_row_r, tgt_col_r;
  logic            free_b;
  logic [CntW-1:0] total_b;
  logic            accept;

  assign accept     = in_ch.valid & in_ch.ready;
  assign start_ok   = ({1'b0, in_ch.start_row} < side_use) &&
                      ({1'b0, in_ch.start_col} < side_use);
  assign here_r_pos = {{(PosW-CoordW){1'b0}}, here_row_r};
  assign here_c_pos = {{(PosW-CoordW){1'b0}}, here_col_r};
  assign side_pos   = {{(PosW-SideW){1'b0}}, side_use};
  assign dir_a      = i_r + pick_r;
  assign nb_a       = DirW'(j_r - LookW'(1));
  assign r_a = here_r_pos + knight_dr(dir_a) + ((j_r != '0) ? knight_dr(nb_a) : pos_t'(0));
  assign c_a = here_c_pos + knight_dc(dir_a) + ((j_r != '0) ? knight_dc(nb_a) : pos_t'(0));
  assign onb_a = (r_a >= pos_t'(0)) && (r_a < side_pos) &&
                 (c_a >= pos_t'(0)) && (c_a < side_pos);
  assign scan_last = (i_r == LastDir) && (j_r == LastLook);
  assign found  = (best_r != NoCount);
  assign tgt_r  = here_r_pos + knight_dr(bdir_r);
  assign tgt_c  = here_c_pos + knight_dc(bdir_r);
  assign free_b = pb_onb_r & ~map_rdata[pb_col_r];
  assign total_b = cnt_r + {{(CntW-1){1'b0}}, free_b};

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_CLEAR: begin
        if (sw_r == LastRow) state_nxt = set_en_r ? ST_DONE : ST_IDLE;
      end
      ST_IDLE: begin
        if (accept) begin
          if (in_ch.action == ActStep) state_nxt = ST_SCAN;
          else                         state_nxt = start_ok ? ST_CLEAR : ST_DONE;
        end
      end
      ST_SCAN: begin
        if (scan_last) state_nxt = ST_TAIL;
      end
      ST_TAIL:   state_nxt = ST_RMW_RD;
      ST_RMW_RD: state_nxt = found ? ST_RMW_WR : ST_DONE;
      ST_RMW_WR: state_nxt = ST_DONE;
      ST_DONE: begin
        if (res_ready) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // outputs: handshake and RAM ports
  always_comb begin
    in_ch.ready = 1'b0;
    res_valid   = 1'b0;
    map_we      = 1'b0;
    map_waddr   = sw_r;
    map_wdata   = '0;
    map_raddr   = r_a[RowIdxW-1:0];
    case (state_r)
      ST_CLEAR: begin
        map_we = 1'b1;
        if (set_en_r && (CoordW'(sw_r) == srow_r))
          map_wdata = MAX_SIDE'(1) << scol_r;
      end
      ST_IDLE:   in_ch.ready = 1'b1;
      ST_RMW_RD: map_raddr = tgt_r[RowIdxW-1:0];
      ST_RMW_WR: begin
        map_we    = 1'b1;
        map_waddr = tgt_row_r[RowIdxW-1:0];
        map_wdata = map_rdata | (MAX_SIDE'(1) << tgt_col_r);
      end
      ST_DONE:   res_valid = 1'b1;
      default: ;
    endcase
  end

  assign res = '{moved: moved_r, cur_row: here_row_r, cur_col: here_col_r,
                 move_number: count_r};

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= ST_CLEAR;
      sw_r       <= '0;
      set_en_r   <= 1'b0;
      pb_vld_r   <= 1'b0;
      here_row_r <= '0;
      here_col_r <= '0;
      count_r    <= '0;
    end else begin
      state_r  <= state_nxt;
      pb_vld_r <= (state_r == ST_SCAN);
      if (state_r == ST_CLEAR) sw_r <= sw_r + RowIdxW'(1);
      if (accept && in_ch.action == ActStart && start_ok) begin
        set_en_r   <= 1'b1;
        sw_r       <= '0;
        here_row_r <= in_ch.start_row;
        here_col_r <= in_ch.start_col;
        count_r    <= '0;
      end
      if (state_r == ST_RMW_WR) begin
        here_row_r <= tgt_row_r;
        here_col_r <= tgt_col_r;
        count_r    <= count_r + StepW'(1);
      end
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    if (accept) begin
      srow_r  <= in_ch.start_row;
      scol_r  <= in_ch.start_col;
      pick_r  <= in_ch.rotation_pick;
      moved_r <= (in_ch.action == ActStart) && start_ok;
      i_r     <= '0;
      j_r     <= '0;
      best_r  <= NoCount;
      bdir_r  <= '0;
    end
    // lookup counters
    if (state_r == ST_SCAN) begin
      if (j_r == LastLook) begin
        j_r <= '0;
        i_r <= i_r + DirW'(1);
      end else begin
        j_r <= j_r + LookW'(1);
      end
    end
    // stage after the RAM read
    pb_j0_r    <= (j_r == '0);
    pb_jlast_r <= (j_r == LastLook);
    pb_onb_r   <= onb_a;
    pb_col_r   <= c_a[RowIdxW-1:0];
    pb_dir_r   <= dir_a;
    if (pb_vld_r) begin
      if (pb_j0_r) begin
        cand_free_r <= free_b;
        cnt_r       <= '0;
      end else begin
        cnt_r <= total_b;
        if (pb_jlast_r && cand_free_r && (total_b < best_r)) begin
          best_r <= total_b;
          bdir_r <= pb_dir_r;
        end
      end
    end
    // commit the chosen square
    if (state_r == ST_RMW_RD) begin
      tgt_row_r <= tgt_r[CoordW-1:0];
      tgt_col_r <= tgt_c[CoordW-1:0];
      moved_r   <= found;
    end
  end

endmodule
